/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-assertion wrappers, clocked on rising edge, reset-gated.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define LCC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent, outside reset.
`define LCC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/lcc_pkg.sv */
// ----------------------------------------------------------------------------
// lcc_pkg
// Types and constants shared by the card number checker modules.
// ----------------------------------------------------------------------------
package lcc_pkg;

  localparam int CARD_WIDTH  = 54;
  // Decimal digits needed for any CARD_WIDTH-bit value (2^54 - 1 has 17).
  localparam int NUM_DIGITS  = 17;
  localparam int BCD_W       = NUM_DIGITS * 4;
  localparam int BIT_CNT_W   = $clog2(CARD_WIDTH);
  localparam int IDX_W       = $clog2(NUM_DIGITS);
  localparam int COUNT_W     = 5;
  localparam int PAIR_W      = 7;
  localparam int CLASS_W     = 2;

  localparam logic [CLASS_W-1:0] CLS_INVALID = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_15_3X   = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_16_5X   = 2'd2;
  localparam logic [CLASS_W-1:0] CLS_4X      = 2'd3;

  localparam logic [COUNT_W-1:0] LEN_13 = 5'd13;
  localparam logic [COUNT_W-1:0] LEN_15 = 5'd15;
  localparam logic [COUNT_W-1:0] LEN_16 = 5'd16;

  localparam logic [PAIR_W-1:0] PAIR_34 = 7'd34;
  localparam logic [PAIR_W-1:0] PAIR_37 = 7'd37;
  localparam logic [PAIR_W-1:0] PAIR_51 = 7'd51;
  localparam logic [PAIR_W-1:0] PAIR_55 = 7'd55;
  localparam logic [PAIR_W-1:0] PAIR_40 = 7'd40;
  localparam logic [PAIR_W-1:0] PAIR_49 = 7'd49;

  typedef struct packed {
    logic load;     // capture a new card number, clear the datapath
    logic shift;    // one double-dabble step
    logic scan;     // consume the lowest decimal digit
    logic publish;  // move the result into the output register
  } lcc_cmd_t;

  typedef struct packed {
    logic conv_last;  // this shift takes the last binary bit
    logic scan_last;  // this scan step takes the last digit
  } lcc_status_t;

endpackage

/* src/lcc_ctrl.sv */
// ----------------------------------------------------------------------------
// lcc_ctrl
// Sequencer: load, binary-to-BCD conversion, digit scan, result hand-off.
// ----------------------------------------------------------------------------
module lcc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  lcc_pkg::lcc_status_t status,
  output lcc_pkg::lcc_cmd_t    cmd
);
  import lcc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.shift = 1'b1;
        if (status.conv_last) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        // hold the finished result until the output register drains
        if (slot_free) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

/* src/lcc_datapath.sv */
// ----------------------------------------------------------------------------
// lcc_datapath
// Bit-serial double dabble, digit-serial Luhn sum, class decode, output beat.
// ----------------------------------------------------------------------------
module lcc_datapath #(
  parameter int MAX_DIGITS = 16
) (
  input  logic                            clk,
  input  lcc_pkg::lcc_cmd_t               cmd,
  input  logic [lcc_pkg::CARD_WIDTH-1:0]  card_number,
  output lcc_pkg::lcc_status_t            status,
  output logic [lcc_pkg::CLASS_W-1:0]     issuer_class,
  output logic                            checksum_ok,
  output logic [lcc_pkg::COUNT_W-1:0]     digit_count,
  output logic [lcc_pkg::PAIR_W-1:0]      leading_pair
);
  import lcc_pkg::*;

  localparam logic [IDX_W-1:0]     IDX_LAST  = IDX_W'(NUM_DIGITS - 1);
  localparam logic [BIT_CNT_W-1:0] BIT_LAST  = BIT_CNT_W'(CARD_WIDTH - 1);
  localparam logic [IDX_W-1:0]     IDX_LIMIT = IDX_W'(MAX_DIGITS);
  // digit positions at or above the limit exist only when the limit is below NUM_DIGITS
  localparam bit                   LIMIT_ACTIVE = (MAX_DIGITS < NUM_DIGITS);

  logic [CARD_WIDTH-1:0] bin;
  logic [BCD_W-1:0]      bcd;
  logic [BCD_W-1:0]      bcd_adj;
  logic [BIT_CNT_W-1:0]  bit_cnt;
  logic [IDX_W-1:0]      idx;
  logic [3:0]            sum;
  logic [3:0]            sum_next;
  logic [COUNT_W-1:0]    count;
  logic [PAIR_W-1:0]     pair;
  logic [3:0]            prev;
  logic                  ovf;

  logic [3:0]            d;
  logic [4:0]            dbl;
  logic [3:0]            term;
  logic [4:0]            acc;
  logic                  take_lead;
  logic [PAIR_W-1:0]     pair_new;
  logic                  ok;
  logic [CLASS_W-1:0]    cls;

  assign status.conv_last = (bit_cnt == BIT_LAST);
  assign status.scan_last = (idx == IDX_LAST);

  // add 3 to every BCD digit of 5 or more ahead of the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  // Luhn term of the current digit; odd index means an even position from the right
  always_comb begin
    d        = bcd[3:0];
    dbl      = {d, 1'b0};
    term     = idx[0] ? ((dbl > 5'd9) ? 4'(dbl - 5'd9) : dbl[3:0]) : d;
    acc      = {1'b0, sum} + {1'b0, term};
    sum_next = (acc >= 5'd10) ? 4'(acc - 5'd10) : acc[3:0];
    take_lead = (d != 4'd0) || (idx == '0);
    pair_new = (idx == '0) ? PAIR_W'(d)
                           : PAIR_W'({d, 3'b000}) + PAIR_W'({d, 1'b0}) + PAIR_W'(prev);
  end

  always_comb begin
    ok  = (sum == 4'd0);
    cls = CLS_INVALID;
    if (ok) begin
      if (count == LEN_15 && (pair == PAIR_34 || pair == PAIR_37)) begin
        cls = CLS_15_3X;
      end else if (count == LEN_16 && pair >= PAIR_51 && pair <= PAIR_55) begin
        cls = CLS_16_5X;
      end else if ((count == LEN_13 || count == LEN_16) && pair >= PAIR_40
                   && pair <= PAIR_49) begin
        cls = CLS_4X;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin     <= card_number;
      bcd     <= '0;
      bit_cnt <= '0;
      idx     <= '0;
      sum     <= '0;
      count   <= COUNT_W'(1);
      pair    <= '0;
      prev    <= '0;
      ovf     <= 1'b0;
    end
    if (cmd.shift) begin
      bcd     <= {bcd_adj[BCD_W-2:0], bin[CARD_WIDTH-1]};
      bin     <= {bin[CARD_WIDTH-2:0], 1'b0};
      bit_cnt <= bit_cnt + 1'b1;
    end
    if (cmd.scan) begin
      bcd  <= {4'd0, bcd[BCD_W-1:4]};
      sum  <= sum_next;
      prev <= d;
      if (take_lead) begin
        count <= COUNT_W'(idx) + COUNT_W'(1);
        pair  <= pair_new;
      end
      if (LIMIT_ACTIVE && idx >= IDX_LIMIT && d != 4'd0) ovf <= 1'b1;
      if (!status.scan_last) idx <= idx + 1'b1;
    end
    if (cmd.publish) begin
      issuer_class <= ovf ? CLS_INVALID : cls;
      checksum_ok  <= ovf ? 1'b0 : ok;
      digit_count  <= ovf ? '0 : count;
      leading_pair <= ovf ? '0 : pair;
    end
  end

endmodule

/* src/luhn_card_number_checker.sv */
// ----------------------------------------------------------------------------
// luhn_card_number_checker: Luhn mod-10 check and issuer class of a card number
// Each input beat goes through 54 conversion steps (one bit each), 17 digit
// steps (one digit each) and a hand-off; a new beat is taken only from the cycle
// after hand-off, so one card number is in flight at a time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module luhn_card_number_checker #(
  parameter int MAX_DIGITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lcc_pkg::CARD_WIDTH-1:0]  card_number,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lcc_pkg::CLASS_W-1:0]     issuer_class,
  output logic                            checksum_ok,
  output logic [lcc_pkg::COUNT_W-1:0]     digit_count,
  output logic [lcc_pkg::PAIR_W-1:0]      leading_pair
);
  import lcc_pkg::*;

  // Reset (synchronous) returns the sequencer to idle and drops out_valid;
  // the datapath registers are payload only, rewritten on every load or hand-off.

  lcc_cmd_t    cmd;
  lcc_status_t status;

  // Sequencer: idle -> convert (one binary bit per cycle, MSB first) ->
  // scan (one decimal digit per cycle, least significant first) -> done.
  // Done waits only while the output register still holds an untaken beat;
  // the output register itself keeps the finished beat while the next card
  // number is accepted and converted.
  lcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: double-dabble shifter into 17 BCD digits, then a digit scan
  // that accumulates the Luhn sum modulo ten, tracks the highest nonzero
  // digit (digit count and leading pair) and flags numbers beyond the
  // MAX_DIGITS limit, which report all-zero fields.
  lcc_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .card_number  (card_number),
    .status       (status),
    .issuer_class (issuer_class),
    .checksum_ok  (checksum_ok),
    .digit_count  (digit_count),
    .leading_pair (leading_pair)
  );

  // One item at a time: an accepted beat closes the input until hand-off.
  `LCC_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "input reopened while busy")
  // Never overwrite a result beat that has not been taken.
  `LCC_ASSERT(a_publish_slot_free, clk, rst, !cmd.publish || !out_valid || out_ready, "result overwritten")
  // A named issuer class implies a passing checksum.
  `LCC_ASSERT(a_class_needs_ok, clk, rst, !out_valid || issuer_class == CLS_INVALID || checksum_ok, "class without checksum")
  // The overflow marker (zero digit count) clears the leading pair and checksum_ok.
  `LCC_ASSERT(a_overflow_zero, clk, rst, !(out_valid && digit_count == '0) || (leading_pair == '0 && !checksum_ok), "overflow beat not cleared")

endmodule
